@@ rtl/siv_pkg.sv @@
// ----------------------------------------------------------------------------
// Schnorr verify package
// Register indexes and reset values shared by the verify core and its bench.
// ----------------------------------------------------------------------------
package siv_pkg;

   localparam int unsigned REG_WIDTH = 32;
   localparam int unsigned CSR_IDX_WIDTH = 2;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_MODULUS    = 2'd0,
      CSR_GENERATOR  = 2'd1,
      CSR_PUBLIC_KEY = 2'd2,
      CSR_UNUSED     = 2'd3
   } csr_idx_type;

   localparam logic [REG_WIDTH-1:0] MODULUS_RESET    = 32'd997;
   localparam logic [REG_WIDTH-1:0] GENERATOR_RESET  = 32'd9;
   localparam logic [REG_WIDTH-1:0] PUBLIC_KEY_RESET = 32'd1;

endpackage

@@ rtl/schnorr_identification_verify_core.sv @@
// ----------------------------------------------------------------------------
// Schnorr identification verify core
// Checks g^z == a * y^c (mod p) for one transcript per word.
// ----------------------------------------------------------------------------
// Channel | Direction | Ports                                  | Width
// req     | in        | req_commitment/challenge/response      | 32 each
// rsp     | out       | rsp_accept                             | 1
// csr     | in        | csr_index, csr_data                    | 2, 32
//
// A word reduces g mod p and raises it to z, then reduces y mod p and raises
// it to c, then reduces a mod p. Each exponent is walked bit by bit from the
// low end: every bit squares, and a set bit first multiplies the accumulator
// by the square. A final multiply and compare close the word; a zero modulus
// is rejected without running any reduction or exponent step.
// Reset restores p = 997, g = 9, y = 1. A stalled result holds in rsp and
// the core takes no new word until it is delivered. csr is always ready.
// ----------------------------------------------------------------------------
module schnorr_identification_verify_core #(
   parameter int unsigned MOD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [siv_pkg::REG_WIDTH-1:0] req_commitment,
   input  logic [siv_pkg::REG_WIDTH-1:0] req_challenge,
   input  logic [siv_pkg::REG_WIDTH-1:0] req_response,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_accept,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [siv_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [siv_pkg::REG_WIDTH-1:0] csr_data
);
   import siv_pkg::*;

   localparam int unsigned W  = MOD_WIDTH;
   localparam int unsigned RW = REG_WIDTH;
   localparam int unsigned EW = $clog2(RW);

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_INIT  = 10'b0000000010,
      ST_RED   = 10'b0000000100,
      ST_BIT   = 10'b0000001000,
      ST_MACC  = 10'b0000010000,
      ST_MSQ   = 10'b0000100000,
      ST_NEXT  = 10'b0001000000,
      ST_FINAL = 10'b0010000000,
      ST_CMP   = 10'b0100000000,
      ST_RSP   = 10'b1000000000
   } state_type;

   state_type      state_ff, state_in;
   logic [RW-1:0]  modulus_ff, generator_ff, public_key_ff;
   logic [RW-1:0]  a_ff, a_in, c_ff, c_in, z_ff, z_in;
   logic [W-1:0]   m_ff, m_in;
   logic [W-1:0]   acc_ff, acc_in, sq_ff, sq_in, lhs_ff, lhs_in;
   logic [W-1:0]   ared_ff, ared_in;
   logic [1:0]     red_ff, red_in;     // which operand is being reduced
   logic           pass_ff, pass_in;   // 0: g^z, 1: y^c
   logic [EW-1:0]  bit_ff, bit_in;
   logic           accept_ff, accept_in;
   logic           mm_start;
   logic [W-1:0]   mm_x, mm_y, mm_p;
   logic           mm_done;
   logic [W-1:0]   one_mod;
   logic           e_bit;

   siv_mulmod #(.W(W)) u_mulmod (
      .clock(clock), .reset(reset), .start(mm_start), .x(mm_x), .y(mm_y),
      .m(m_ff), .done(mm_done), .product(mm_p)
   );

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RSP);
   assign rsp_accept = accept_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff    <= MODULUS_RESET;
         generator_ff  <= GENERATOR_RESET;
         public_key_ff <= PUBLIC_KEY_RESET;
      end else if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_MODULUS:    modulus_ff    <= csr_data;
            CSR_GENERATOR:  generator_ff  <= csr_data;
            CSR_PUBLIC_KEY: public_key_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign one_mod = (m_ff == W'(1)) ? '0 : W'(1);
   assign e_bit   = pass_ff ? c_ff[bit_ff] : z_ff[bit_ff];

   // Operand reduction: v mod m by restoring division over the full 32-bit
   // value, one bit per cycle in ST_RED.
   logic [RW-1:0] rv_ff, rv_in;
   logic [W:0]    rr_ff, rr_in;
   logic [EW:0]   rc_ff, rc_in;
   logic [W+1:0]  rr_sh;

   always_comb begin
      state_in  = state_ff;
      a_in = a_ff; c_in = c_ff; z_in = z_ff; m_in = m_ff;
      acc_in = acc_ff; sq_in = sq_ff; lhs_in = lhs_ff; ared_in = ared_ff;
      red_in = red_ff; pass_in = pass_ff; bit_in = bit_ff;
      accept_in = accept_ff;
      rv_in = rv_ff; rr_in = rr_ff; rc_in = rc_ff;
      mm_start = 1'b0; mm_x = acc_ff; mm_y = sq_ff;
      rr_sh = {rr_ff, rv_ff[RW-1]};
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               a_in = req_commitment; c_in = req_challenge; z_in = req_response;
               m_in = W'(modulus_ff);
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            if (m_ff == '0) begin
               accept_in = 1'b0;
               state_in  = ST_RSP;
            end else begin
               red_in = 2'd0;
               rv_in  = generator_ff; rr_in = '0; rc_in = (EW+1)'(RW);
               state_in = ST_RED;
            end
         end
         ST_RED: begin
            if (rc_ff != '0) begin
               // One restoring-division step per cycle.
               rr_in = (rr_sh >= {2'b0, m_ff}) ? (W+1)'(rr_sh - {2'b0, m_ff})
                                                : rr_sh[W:0];
               rv_in = {rv_ff[RW-2:0], 1'b0};
               rc_in = rc_ff - 1'b1;
            end else begin
               unique case (red_ff)
                  2'd0: begin
                     sq_in = rr_ff[W-1:0]; acc_in = one_mod;
                     pass_in = 1'b0; bit_in = '0;
                     state_in = ST_BIT;
                  end
                  2'd1: begin
                     sq_in = rr_ff[W-1:0]; acc_in = one_mod;
                     pass_in = 1'b1; bit_in = '0;
                     state_in = ST_BIT;
                  end
                  default: begin
                     ared_in = rr_ff[W-1:0];
                     mm_start = 1'b1; mm_x = rr_ff[W-1:0]; mm_y = acc_ff;
                     state_in = ST_FINAL;
                  end
               endcase
            end
         end
         ST_BIT: begin
            mm_start = 1'b1;
            if (e_bit) begin
               mm_x = acc_ff; mm_y = sq_ff; state_in = ST_MACC;
            end else begin
               mm_x = sq_ff; mm_y = sq_ff; state_in = ST_MSQ;
            end
         end
         ST_MACC: begin
            if (mm_done) begin
               acc_in = mm_p;
               mm_start = 1'b1; mm_x = sq_ff; mm_y = sq_ff;
               state_in = ST_MSQ;
            end
         end
         ST_MSQ: begin
            if (mm_done) begin
               sq_in = mm_p;
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (bit_ff == EW'(RW - 1)) begin
               if (!pass_ff) begin
                  lhs_in = acc_ff;
                  red_in = 2'd1;
                  rv_in = public_key_ff;
               end else begin
                  red_in = 2'd2;
                  rv_in = a_ff;
               end
               rr_in = '0; rc_in = (EW+1)'(RW);
               state_in = ST_RED;
            end else begin
               bit_in = bit_ff + 1'b1;
               state_in = ST_BIT;
            end
         end
         ST_FINAL: begin
            if (mm_done) state_in = ST_CMP;
         end
         ST_CMP: begin
            accept_in = (mm_p == lhs_ff);
            state_in  = ST_RSP;
         end
         ST_RSP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rc_ff    <= '0;
      end else begin
         state_ff <= state_in;
         rc_ff    <= rc_in;
      end
      a_ff <= a_in; c_ff <= c_in; z_ff <= z_in; m_ff <= m_in;
      acc_ff <= acc_in; sq_ff <= sq_in; lhs_ff <= lhs_in; ared_ff <= ared_in;
      red_ff <= red_in; pass_ff <= pass_in; bit_ff <= bit_in;
      accept_ff <= accept_in; rv_ff <= rv_in; rr_ff <= rr_in;
   end

   a_req_only_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == ST_INIT)
      else $error("accepted word did not start work");
   a_zero_mod_reject: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INIT && m_ff == '0) |=> (rsp_valid && !rsp_accept))
      else $error("zero modulus not rejected");
   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_accept)))
      else $error("result dropped while stalled");
   a_red_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RED && rc_ff == '0) |-> rr_ff < {1'b0, m_ff})
      else $error("operand reduction out of range");
   a_ared_used: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINAL) |-> ared_ff < m_ff)
      else $error("commitment not reduced");

endmodule

@@ rtl/siv_mulmod.sv @@
// ----------------------------------------------------------------------------
// Modular multiplier / reducer
// Bit-serial shift-and-add computing (x * y) mod m, one multiplier bit per
// cycle. Operands must be below m and m must be nonzero.
// ----------------------------------------------------------------------------
module siv_mulmod #(
   parameter int unsigned W = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] x,
   input  logic [W-1:0] y,
   input  logic [W-1:0] m,
   output logic         done,
   output logic [W-1:0] product
);
   localparam int unsigned CW = $clog2(W + 1);

   logic [W-1:0]  acc_ff, acc_in;
   logic [W-1:0]  x_ff, x_in;
   logic [W-1:0]  y_ff, y_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [W:0]    dbl, dbl_red, sum, sum_red;
   logic [W-1:0]  acc2;

   always_comb begin
      // Double, then conditionally add x; each step reduced by one compare.
      dbl     = {acc_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
      sum     = dbl_red + {1'b0, x_ff};
      sum_red = (sum >= {1'b0, m}) ? sum - {1'b0, m} : sum;
      acc2    = y_ff[W-1] ? sum_red[W-1:0] : dbl_red[W-1:0];
      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         x_in    = x;
         y_in    = y;
         cnt_in  = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc2;
         y_in   = {y_ff[W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("done without a busy cycle");
   a_acc_reduced: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !start && x_ff < m && acc_ff < m && $stable(m))
         |=> acc_ff < m) else $error("accumulator left unreduced");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start) else $error("start while busy");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Schnorr verify core testbench
// Drives transcripts through the core under several modulus, generator and
// key settings, and compares each accept flag with a local predictor.
// ----------------------------------------------------------------------------

class accept_scoreboard;
   bit          pending_accepts[$];
   int unsigned fail_count = 0;

   function void note_transcript(bit accept);
      pending_accepts.push_back(accept);
   endfunction

   function void check_accept(bit actual);
      bit expected;
      if (pending_accepts.size() == 0) begin
         $error("accept: no word expected, got %0d", actual);
         fail_count++;
      end else begin
         expected = pending_accepts.pop_front();
         if (expected !== actual) begin
            $error("accept: expected %0d, actual %0d", expected, actual);
            fail_count++;
         end
      end
   endfunction
endclass

module tb;
   import siv_pkg::*;

   localparam int unsigned MOD_WIDTH = 32;
   localparam int unsigned STALL_LIMIT = 100000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_commitment = '0;
   logic [31:0] req_challenge = '0;
   logic [31:0] req_response = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_accept;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   csr_idx_type csr_index = CSR_MODULUS;
   logic [31:0] csr_data = '0;

   logic [63:0] modulus_reg = 64'(MODULUS_RESET);
   logic [63:0] generator_reg = 64'(GENERATOR_RESET);
   logic [63:0] public_key_reg = 64'(PUBLIC_KEY_RESET);

   accept_scoreboard board = new();
   bit          rx_hold = 1'b0;
   bit          timed_out = 1'b0;
   int unsigned idle_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   schnorr_identification_verify_core #(.MOD_WIDTH(MOD_WIDTH)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_commitment(req_commitment), .req_challenge(req_challenge),
      .req_response(req_response),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_accept(rsp_accept),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // Product modulo m by doubling and adding, exact for any 64-bit m.
   function automatic logic [63:0] mult_mod(logic [63:0] x, logic [63:0] y,
                                            logic [63:0] m);
      logic [63:0] acc;
      acc = 0;
      for (int i = 63; i >= 0; i--) begin
         acc = (acc >= m - acc) ? acc - (m - acc) : acc + acc;
         if (y[i])
            acc = (acc >= m - x) ? acc - (m - x) : acc + x;
      end
      return acc;
   endfunction

   function automatic logic [63:0] power_mod(logic [63:0] base, logic [31:0] e,
                                             logic [63:0] m);
      logic [63:0] acc;
      logic [63:0] sq;
      acc = 1 % m;
      sq = base % m;
      for (int i = 0; i < 32; i++) begin
         if (e[i])
            acc = mult_mod(acc, sq, m);
         sq = mult_mod(sq, sq, m);
      end
      return acc;
   endfunction

   function automatic bit transcript_holds(logic [31:0] a, logic [31:0] c,
                                           logic [31:0] z);
      logic [63:0] m;
      m = modulus_reg & ({64{1'b1}} >> (64 - MOD_WIDTH));
      if (m == 0)
         return 1'b0;
      return power_mod(generator_reg, z, m) ==
             mult_mod(64'(a) % m, power_mod(public_key_reg, c, m), m);
   endfunction

   task automatic write_reg(csr_idx_type idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_MODULUS:    modulus_reg = 64'(value);
         CSR_GENERATOR:  generator_reg = 64'(value);
         CSR_PUBLIC_KEY: public_key_reg = 64'(value);
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic send_transcript(logic [31:0] a, logic [31:0] c, logic [31:0] z,
                                  bit use_gaps);
      if (use_gaps)
         repeat ($urandom_range(0, 3)) @(posedge clock);
      req_valid <= 1'b1;
      req_commitment <= a;
      req_challenge <= c;
      req_response <= z;
      do @(posedge clock); while (!req_ready);
      board.note_transcript(transcript_holds(a, c, z));
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (board.pending_accepts.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Mostly small exponents keep the run short; a few use full width.
   task automatic send_random(int unsigned count);
      logic [31:0] a, c, z;
      for (int unsigned i = 0; i < count; i++) begin
         a = $urandom();
         c = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 255);
         z = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 255);
         // Half the time set a = g^z mod p, which accepts whenever y^c = 1 mod p.
         if ($urandom_range(0, 1) && modulus_reg != 0)
            a = 32'(power_mod(generator_reg, z, modulus_reg));
         send_transcript(a, c, z, 1'b1);
      end
   endtask

   // Result side: random stalls, plus a long hold-off on request.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_accept(rsp_accept);
   end

   initial begin
      int unsigned wait_n;
      forever begin
         @(posedge clock);
         if (rx_hold) begin
            rsp_ready <= 1'b0;
            repeat (20000) @(posedge clock);
            rx_hold = 1'b0;
         end
         wait_n = $urandom_range(0, 3);
         if (wait_n != 0 && $urandom_range(0, 3) != 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("tb: FAIL");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values: g = 9, y = 1, p = 997, so a = 9^z mod 997 accepts.
      send_transcript(32'd81, 32'd5, 32'd2, 1'b0);
      send_transcript(32'd82, 32'd5, 32'd2, 1'b0);
      send_transcript(32'd1, 32'd0, 32'd0, 1'b0);
      send_transcript(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send_transcript(32'd0, 32'hFFFF_FFFF, 32'd0, 1'b0);
      wait_drained();

      write_reg(CSR_GENERATOR, 32'd5);
      write_reg(CSR_PUBLIC_KEY, 32'd2000);
      write_reg(CSR_UNUSED, 32'd12345);
      send_transcript(32'd997, 32'd3, 32'd7, 1'b0);
      send_transcript(32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
      wait_drained();

      // Modulus one: both sides reduce to zero.
      write_reg(CSR_MODULUS, 32'd1);
      send_transcript(32'd7, 32'd0, 32'd0, 1'b0);
      send_transcript(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      wait_drained();

      // Modulus zero: always rejected.
      write_reg(CSR_MODULUS, 32'd0);
      send_transcript(32'd1, 32'd0, 32'd0, 1'b0);
      send_transcript(32'd0, 32'd1, 32'd1, 1'b0);
      wait_drained();

      write_reg(CSR_MODULUS, 32'd2);
      write_reg(CSR_GENERATOR, 32'hFFFF_FFFF);
      write_reg(CSR_PUBLIC_KEY, 32'd0);
      send_transcript(32'd1, 32'd0, 32'd9, 1'b0);
      send_transcript(32'd3, 32'd4, 32'd1, 1'b0);
      wait_drained();

      write_reg(CSR_MODULUS, 32'hFFFF_FFFB);
      write_reg(CSR_GENERATOR, 32'd0);
      write_reg(CSR_PUBLIC_KEY, 32'hFFFF_FFFF);
      send_transcript(32'd0, 32'd1, 32'd3, 1'b0);
      send_transcript(32'hFFFF_FFFA, 32'd0, 32'd0, 1'b0);
      wait_drained();

      // Random part under a few settings; the receiver stalls long once.
      write_reg(CSR_MODULUS, 32'd997);
      write_reg(CSR_GENERATOR, 32'd9);
      write_reg(CSR_PUBLIC_KEY, 32'd81);
      rx_hold = 1'b1;
      send_random(35);
      wait_drained();

      write_reg(CSR_MODULUS, 32'hFFFF_FFFB);
      write_reg(CSR_GENERATOR, $urandom());
      write_reg(CSR_PUBLIC_KEY, 32'd1);
      send_random(40);
      wait_drained();

      write_reg(CSR_MODULUS, $urandom_range(2, 65535));
      write_reg(CSR_GENERATOR, $urandom());
      write_reg(CSR_PUBLIC_KEY, $urandom());
      send_random(40);

      while (board.pending_accepts.size() != 0) @(posedge clock);
      repeat (9000) @(posedge clock);
      if (board.fail_count == 0 && board.pending_accepts.size() == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end
endmodule

@@ filelist.f @@
rtl/siv_pkg.sv
rtl/siv_mulmod.sv
rtl/schnorr_identification_verify_core.sv
tb/tb.sv
